// ----- rtl/core/lz77fb_pkg.sv -----
package lz77fb_pkg;

   // Fixed field widths of the stream format and result item
   localparam int BYTE_W   = 8;
   localparam int OUT_W    = 64;
   localparam int COUNT_W  = 4;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 32;
   localparam int DIST_W   = 12;
   localparam int RUN_W    = 9;

   localparam int DEF_WINDOW_BYTES = 4096;
   localparam int DEF_OUT_LANES    = 8;

   localparam logic [RUN_W-1:0] SHORT_BIAS = 9'd2;
   localparam logic [RUN_W-1:0] LONG_BIAS  = 9'h12;
   localparam logic [RUN_W-1:0] MAX_RUN    = 9'd273;
   localparam logic [3:0]       FLAG_BITS  = 4'd8;

   localparam logic [STATUS_W-1:0] STAT_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_BEFORE_START = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_COMPLETE     = 2'd2;

   // What the captured byte means in the current parse position
   typedef enum logic [2:0] {
      KIND_COMPLETE,
      KIND_FLAG,
      KIND_FIRST,
      KIND_SECOND,
      KIND_LITERAL,
      KIND_RUN
   } kind_type;

   typedef struct packed {
      logic capture;
      logic decode_apply;
      logic rd;
      logic wr;
      logic emit_run;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     ref_bad;
      logic     out_free;
      logic     wr_flush;
      logic     run_done;
   } stat_type;

endpackage

// ----- rtl/core/lz77fb_ctrl.sv -----
module lz77fb_ctrl
   import lz77fb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD,
      ST_WR,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.kind)
               KIND_FLAG, KIND_FIRST, KIND_SECOND: begin
                  cmd.decode_apply = 1'b1;
                  state_in         = ST_IDLE;
               end
               KIND_COMPLETE, KIND_LITERAL: begin
                  if (stat.out_free) begin
                     cmd.decode_apply = 1'b1;
                     state_in         = ST_IDLE;
                  end
               end
               KIND_RUN: begin
                  if (stat.ref_bad) begin
                     if (stat.out_free) begin
                        cmd.decode_apply = 1'b1;
                        state_in         = ST_IDLE;
                     end
                  end else begin
                     cmd.decode_apply = 1'b1;
                     state_in         = ST_RD;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            cmd.wr   = 1'b1;
            state_in = stat.wr_flush ? ST_EMIT : ST_RD;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_run = 1'b1;
               state_in     = stat.run_done ? ST_IDLE : ST_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

   // A history write always follows its read
   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |-> ($past(state_ff) == ST_RD))
      else $error("write step without preceding read");

   a_emit_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |->
         ($past(state_ff) == ST_WR || $past(state_ff) == ST_EMIT))
      else $error("emit entered from wrong step");

   a_stall_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall_ff)
      else $error("input open while a byte is in progress");

endmodule

// ----- rtl/core/lz77fb_dpath.sv -----
module lz77fb_dpath
   import lz77fb_pkg::*;
#(
   parameter int WINDOW_BYTES = DEF_WINDOW_BYTES,
   parameter int OUT_LANES    = DEF_OUT_LANES
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [BYTE_W-1:0]   req_compressed_byte,
   input  logic                req_stream_start,
   input  logic                csr_wr_en,
   input  logic [LEN_W-1:0]    csr_wr_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [OUT_W-1:0]    rsp_out_bytes,
   output logic [COUNT_W-1:0]  rsp_byte_count,
   output logic                rsp_last,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_done_res
);

   localparam int ADDR_W = $clog2(WINDOW_BYTES);
   localparam int LANE_W = $clog2(OUT_LANES + 1);

   localparam logic [1:0] PH_ITEM   = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

   logic [BYTE_W-1:0] hist [WINDOW_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   logic [BYTE_W-1:0] byte_ff;
   logic [BYTE_W-1:0] flag_ff;
   logic [3:0]        bits_ff;
   logic [1:0]        phase_ff;
   logic [BYTE_W-1:0] first_ff;
   logic [BYTE_W-1:0] second_ff;
   logic [LEN_W-1:0]  produced_ff;
   logic [LEN_W-1:0]  olen_ff;
   logic [RUN_W-1:0]  remain_ff;
   logic [ADDR_W-1:0] src_ff;
   logic [LANE_W-1:0] lane_ff;
   logic [OUT_W-1:0]  pack_ff;

   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    rsp_bytes_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_last_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_done_ff;

   kind_type          kind;
   logic              done_now;
   logic              ref_bad;
   logic [DIST_W-1:0] ref_dist;
   logic [RUN_W-1:0]  run_len;
   logic [RUN_W-1:0]  run_clamped;
   logic [LEN_W-1:0]  room;
   logic              out_free;
   logic              out_load;
   logic              mem_we;
   logic [BYTE_W-1:0] mem_wd;

   // Classify the captured byte
   always_comb begin
      done_now = (produced_ff >= olen_ff);
      ref_dist = {first_ff[3:0], (phase_ff == PH_SECOND) ? byte_ff : second_ff};
      ref_bad  = ({{(LEN_W-DIST_W){1'b0}}, ref_dist} >= produced_ff);
      run_len  = (phase_ff == PH_SECOND) ? ({5'd0, first_ff[7:4]} + SHORT_BIAS)
                                         : ({1'b0, byte_ff} + LONG_BIAS);
      room     = olen_ff - produced_ff;
      run_clamped = (room < {{(LEN_W-RUN_W){1'b0}}, run_len}) ? room[RUN_W-1:0]
                                                              : run_len;
      if (done_now) begin
         kind = KIND_COMPLETE;
      end else if (phase_ff == PH_SECOND) begin
         kind = (first_ff[7:4] != 4'd0) ? KIND_RUN : KIND_SECOND;
      end else if (phase_ff == PH_THIRD) begin
         kind = KIND_RUN;
      end else if (bits_ff == 4'd0) begin
         kind = KIND_FLAG;
      end else if (flag_ff[7]) begin
         kind = KIND_LITERAL;
      end else begin
         kind = KIND_FIRST;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = cmd.emit_run ||
                     (cmd.decode_apply && (kind == KIND_COMPLETE || kind == KIND_LITERAL ||
                                           (kind == KIND_RUN && ref_bad)));

   assign stat.kind     = kind;
   assign stat.ref_bad  = ref_bad;
   assign stat.out_free = out_free;
   assign stat.wr_flush = (lane_ff == LANE_W'(OUT_LANES - 1)) || (remain_ff == 9'd1);
   assign stat.run_done = (remain_ff == '0);

   assign mem_we = cmd.wr || (cmd.decode_apply && kind == KIND_LITERAL);
   assign mem_wd = cmd.wr ? rd_data_ff : byte_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist[produced_ff[ADDR_W-1:0]] <= mem_wd;
      end
      if (cmd.rd) begin
         rd_data_ff <= hist[src_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff <= req_compressed_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= '0;
         bits_ff      <= '0;
         phase_ff     <= PH_ITEM;
         first_ff     <= '0;
         second_ff    <= '0;
         produced_ff  <= '0;
         olen_ff      <= '0;
         remain_ff    <= '0;
         src_ff       <= '0;
         lane_ff      <= '0;
         pack_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            olen_ff <= csr_wr_data;
         end

         if (cmd.capture && req_stream_start) begin
            flag_ff     <= '0;
            bits_ff     <= '0;
            phase_ff    <= PH_ITEM;
            first_ff    <= '0;
            second_ff   <= '0;
            produced_ff <= '0;
         end

         if (cmd.decode_apply) begin
            case (kind)
               KIND_FLAG: begin
                  flag_ff  <= byte_ff;
                  bits_ff  <= FLAG_BITS;
                  phase_ff <= PH_ITEM;
               end
               KIND_FIRST: begin
                  first_ff <= byte_ff;
                  phase_ff <= PH_SECOND;
               end
               KIND_SECOND: begin
                  second_ff <= byte_ff;
                  phase_ff  <= PH_THIRD;
               end
               KIND_LITERAL: begin
                  produced_ff <= produced_ff + 32'd1;
                  flag_ff     <= {flag_ff[6:0], 1'b0};
                  bits_ff     <= bits_ff - 4'd1;
                  phase_ff    <= PH_ITEM;
               end
               KIND_RUN: begin
                  if (phase_ff == PH_SECOND) begin
                     second_ff <= byte_ff;
                  end
                  flag_ff  <= {flag_ff[6:0], 1'b0};
                  if (bits_ff != 4'd0) begin
                     bits_ff <= bits_ff - 4'd1;
                  end
                  phase_ff <= PH_ITEM;
                  if (!ref_bad) begin
                     remain_ff <= run_clamped;
                     src_ff    <= produced_ff[ADDR_W-1:0] - ADDR_W'(ref_dist) - ADDR_W'(1);
                     lane_ff   <= '0;
                     pack_ff   <= '0;
                  end
               end
               default: phase_ff <= phase_ff;
            endcase
         end

         // Copy one history byte into the next lane
         if (cmd.wr) begin
            produced_ff <= produced_ff + 32'd1;
            src_ff      <= src_ff + ADDR_W'(1);
            remain_ff   <= remain_ff - 9'd1;
            lane_ff     <= lane_ff + LANE_W'(1);
            for (int i = 0; i < OUT_LANES; i++) begin
               if (lane_ff == LANE_W'(i)) begin
                  pack_ff[i*BYTE_W +: BYTE_W] <= rd_data_ff;
               end
            end
         end

         if (cmd.emit_run) begin
            lane_ff <= '0;
            pack_ff <= '0;
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         if (cmd.emit_run) begin
            rsp_bytes_ff  <= pack_ff;
            rsp_count_ff  <= COUNT_W'(lane_ff);
            rsp_last_ff   <= (remain_ff == '0);
            rsp_status_ff <= STAT_OK;
            rsp_done_ff   <= done_now;
         end else if (kind == KIND_LITERAL) begin
            rsp_bytes_ff  <= {{(OUT_W-BYTE_W){1'b0}}, byte_ff};
            rsp_count_ff  <= 4'd1;
            rsp_last_ff   <= 1'b1;
            rsp_status_ff <= STAT_OK;
            rsp_done_ff   <= (({1'b0, produced_ff} + 33'd1) >= {1'b0, olen_ff});
         end else if (kind == KIND_COMPLETE) begin
            rsp_bytes_ff  <= '0;
            rsp_count_ff  <= '0;
            rsp_last_ff   <= 1'b1;
            rsp_status_ff <= STAT_COMPLETE;
            rsp_done_ff   <= 1'b1;
         end else begin
            rsp_bytes_ff  <= '0;
            rsp_count_ff  <= '0;
            rsp_last_ff   <= 1'b1;
            rsp_status_ff <= STAT_BEFORE_START;
            rsp_done_ff   <= done_now;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_bytes  = rsp_bytes_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_done_res   = rsp_done_ff;

   a_empty_is_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_count_ff == '0) |-> (rsp_status_ff != STAT_OK))
      else $error("empty result without status code");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff <= COUNT_W'(OUT_LANES)))
      else $error("result byte count beyond lane count");

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= MAX_RUN)
      else $error("run length beyond longest reference");

endmodule

// ----- rtl/core/lz77_flag_byte_decoder.sv -----
// Yaz0-style LZ77 payload decoder.
// Input channel (req_*): one compressed payload byte per item, taken when
// req_valid is high and req_stall low. req_stream_start marks the first byte
// of a new stream and clears the parse position and the produced count.
// Result channel (rsp_*): up to OUT_LANES decoded bytes per item, first byte
// in bits 7..0, with byte count, last-of-input marker, status and done flag.
// csr_wr_en/csr_wr_data load the stream output length; write it while idle.
// Timing: the core handles one input byte at a time. A flag byte or a
// reference header byte is captured and then decoded. A literal or a
// status result is decoded once the result register is free. A copy of
// N bytes reads and writes the history RAM per byte and emits each result
// when the result register is free; the RAM is read in one step and written
// in the next, so overlapping copies see the byte just written.
// For literals, result valid is registered when the decode step loads it.
// Reset clears parse state, counters and output length; history RAM is not
// cleared, references are range checked against the produced count instead.
// When rsp_stall is high the result register holds its item and the core
// waits; req_stall stays high until the current byte is fully handled.
module lz77_flag_byte_decoder
   import lz77fb_pkg::*;
#(
   parameter int WINDOW_BYTES = DEF_WINDOW_BYTES,
   parameter int OUT_LANES    = DEF_OUT_LANES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_compressed_byte,
   input  logic                req_stream_start,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [OUT_W-1:0]    rsp_out_bytes,
   output logic [COUNT_W-1:0]  rsp_byte_count,
   output logic                rsp_last,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_done_res,
   input  logic                csr_wr_en,
   input  logic [LEN_W-1:0]    csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   // Sequencer: capture, decode, then read/write/emit steps for a copy
   lz77fb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Parse registers, history RAM, lane packing and result register
   lz77fb_dpath #(
      .WINDOW_BYTES (WINDOW_BYTES),
      .OUT_LANES    (OUT_LANES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_compressed_byte (req_compressed_byte),
      .req_stream_start    (req_stream_start),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_bytes       (rsp_out_bytes),
      .rsp_byte_count      (rsp_byte_count),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status),
      .rsp_done_res        (rsp_done_res)
   );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
   import lz77fb_pkg::*;
;

   // Run limits and timing
   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int HOLD_CYCLES   = 3000;
   localparam int SETTLE_CYCLES = 24;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // Where the decoder stands in the compressed stream
   typedef enum bit [1:0] {
      AT_ITEM,
      AT_SECOND,
      AT_THIRD
   } parse_pos_type;

   // One decoded output item, in port order
   typedef struct packed {
      logic [OUT_W-1:0]    bytes;
      logic [COUNT_W-1:0]  count;
      logic                last;
      logic [STATUS_W-1:0] status;
      logic                done;
   } out_beat_type;

   // One compressed byte as offered on the input channel
   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              start;
   } comp_byte_type;

   // Shadow decoder: follows every accepted byte, queues the output items
   // it must cause and checks the items that come back against them.
   class yaz0_tracker;
      bit [BYTE_W-1:0] window [DEF_WINDOW_BYTES];
      bit [BYTE_W-1:0] flags;
      bit [3:0]        flags_left;
      parse_pos_type   pos;
      bit [BYTE_W-1:0] hdr_first;
      bit [BYTE_W-1:0] hdr_second;
      bit [LEN_W-1:0]  produced;
      bit [LEN_W-1:0]  out_len;
      out_beat_type    expected_beats[$];
      int unsigned     mismatches;

      function new();
         pos = AT_ITEM;
      endfunction

      function void set_length(bit [LEN_W-1:0] v);
         out_len = v;
      endfunction

      function void queue_beat(bit [OUT_W-1:0] b, bit [COUNT_W-1:0] n, bit last,
                               bit [STATUS_W-1:0] st);
         out_beat_type beat;
         beat.bytes  = b;
         beat.count  = n;
         beat.last   = last;
         beat.status = st;
         beat.done   = (produced >= out_len);
         expected_beats.push_back(beat);
      endfunction

      // Shift to the next flag bit and go back to expecting an item
      function void close_item();
         flags = flags << 1;
         if (flags_left != 0) flags_left--;
         pos = AT_ITEM;
      endfunction

      function void copy_back(bit [LEN_W-1:0] run_len, bit [DIST_W-1:0] back_dist);
         bit [LEN_W-1:0]  src;
         bit [LEN_W-1:0]  room;
         bit [OUT_W-1:0]  pack;
         bit [BYTE_W-1:0] b;
         int unsigned     lane;
         int unsigned     i;
         close_item();
         // a reference reaching before the first byte of the stream copies nothing
         if ({20'd0, back_dist} + 32'd1 > produced) begin
            queue_beat('0, '0, 1'b1, STAT_BEFORE_START);
            return;
         end
         room = out_len - produced;
         if (run_len > room) run_len = room;
         src  = produced - back_dist - 1;
         lane = 0;
         pack = '0;
         // byte by byte, so an overlapping copy sees the bytes it just wrote
         for (i = 0; i < run_len; i++) begin
            b = window[src[DIST_W-1:0]];
            window[produced[DIST_W-1:0]] = b;
            produced++;
            src++;
            pack |= OUT_W'(b) << (8 * lane);
            lane++;
            if (lane == DEF_OUT_LANES || i + 1 == run_len) begin
               queue_beat(pack, COUNT_W'(lane), i + 1 == run_len, STAT_OK);
               lane = 0;
               pack = '0;
            end
         end
      endfunction

      function void note_byte(bit [BYTE_W-1:0] b, bit start);
         if (start) begin
            flags      = '0;
            flags_left = '0;
            pos        = AT_ITEM;
            hdr_first  = '0;
            hdr_second = '0;
            produced   = '0;
         end
         // past the end: the byte is dropped and only a status item comes back
         if (produced >= out_len) begin
            queue_beat('0, '0, 1'b1, STAT_COMPLETE);
            return;
         end
         case (pos)
            AT_SECOND: begin
               hdr_second = b;
               if (hdr_first[7:4] != 0)
                  copy_back(LEN_W'(hdr_first[7:4]) + LEN_W'(SHORT_BIAS),
                            {hdr_first[3:0], hdr_second});
               else
                  pos = AT_THIRD;
            end
            AT_THIRD: begin
               copy_back(LEN_W'(b) + LEN_W'(LONG_BIAS), {hdr_first[3:0], hdr_second});
            end
            default: begin
               if (flags_left == 0) begin
                  flags      = b;
                  flags_left = FLAG_BITS;
                  pos        = AT_ITEM;
               end else if (flags[7]) begin
                  window[produced[DIST_W-1:0]] = b;
                  produced++;
                  close_item();
                  queue_beat(OUT_W'(b), COUNT_W'(1), 1'b1, STAT_OK);
               end else begin
                  hdr_first = b;
                  pos       = AT_SECOND;
               end
            end
         endcase
      endfunction

      function void report(string field, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
         mismatches++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      endfunction

      function void check_beat(out_beat_type got);
         out_beat_type want;
         if (expected_beats.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item, expected none actual bytes %h count %0d status %0d",
                     $time, got.bytes, got.count, got.status);
            return;
         end
         want = expected_beats.pop_front();
         if (got.bytes !== want.bytes)   report("out_bytes", want.bytes, got.bytes);
         if (got.count !== want.count)   report("byte_count", want.count, got.count);
         if (got.last !== want.last)     report("last", want.last, got.last);
         if (got.status !== want.status) report("status", want.status, got.status);
         if (got.done !== want.done)     report("done_res", want.done, got.done);
      endfunction
   endclass

   // DUT signals, all inputs known from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_compressed_byte = '0;
   logic                req_stream_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [OUT_W-1:0]    rsp_out_bytes;
   logic [COUNT_W-1:0]  rsp_byte_count;
   logic                rsp_last;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_done_res;
   logic                csr_wr_en = 1'b0;
   logic [LEN_W-1:0]    csr_wr_data = '0;

   yaz0_tracker   tracker = new();
   comp_byte_type stim_q[$];
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            hold_left = 0;
   int            cycle_count = 0;

   lz77_flag_byte_decoder #(
      .WINDOW_BYTES(DEF_WINDOW_BYTES),
      .OUT_LANES   (DEF_OUT_LANES)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_compressed_byte(req_compressed_byte),
      .req_stream_start   (req_stream_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_bytes      (rsp_out_bytes),
      .rsp_byte_count     (rsp_byte_count),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status),
      .rsp_done_res       (rsp_done_res),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Hard stop: a hung decoder or a missing output item ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side: check each accepted item, then pick the stall for the next
   // cycle. A pending hold-off forces stall high and counts down here.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_beat({rsp_out_bytes, rsp_byte_count, rsp_last, rsp_status,
                             rsp_done_res});
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic void push_stim(logic [BYTE_W-1:0] d, logic s);
      stim_q.push_back('{d, s});
   endfunction

   // Build compressed streams: mostly well-formed flag groups with random
   // literals and references that stay inside what has been produced, plus
   // raw noise streams, stray out-of-range references, references cut off
   // by a new stream, and bytes sent after the stream is complete.
   function automatic void build_streams(int n_items, longint out_len, int lit_pct,
                                         int long_pct, int big_pct);
      int                added;
      int                k;
      int                i;
      longint            made;
      longint            run_len;
      longint            avail;
      bit                cut;
      bit                fresh;
      bit [BYTE_W-1:0]   flag_bits;
      bit [BYTE_W-1:0]   third;
      bit [3:0]          nib;
      bit [DIST_W-1:0]   back_dist;
      added = 0;
      while (added < n_items) begin
         if ($urandom_range(99) < 8) begin
            // noise: a short stream of raw bytes
            k = $urandom_range(6, 16);
            for (i = 0; i < k; i++) push_stim(BYTE_W'($urandom), i == 0);
            added += k;
         end else begin
            made  = 0;
            cut   = 1'b0;
            fresh = 1'b1;
            while (!cut && added < n_items && made < out_len) begin
               for (i = 0; i < 8; i++) flag_bits[i] = ($urandom_range(99) < lit_pct);
               push_stim(flag_bits, fresh);
               fresh = 1'b0;
               added++;
               for (i = 7; i >= 0 && !cut && made < out_len && added < n_items; i--) begin
                  if (flag_bits[i]) begin
                     push_stim(BYTE_W'($urandom), 1'b0);
                     made++;
                     added++;
                  end else begin
                     avail = (made < DEF_WINDOW_BYTES) ? made : DEF_WINDOW_BYTES;
                     k = $urandom_range(99);
                     if (avail == 0 || k < 5)
                        back_dist = DIST_W'($urandom);
                     else if (k < 15)
                        back_dist = DIST_W'(avail - 1);
                     else if (k < 45)
                        back_dist = DIST_W'($urandom % ((avail < 8) ? avail : 8));
                     else
                        back_dist = DIST_W'($urandom % avail);
                     nib = ($urandom_range(99) < long_pct) ? 4'd0 : 4'($urandom_range(1, 15));
                     push_stim({nib, back_dist[11:8]}, 1'b0);
                     added++;
                     if ($urandom_range(99) < 3) begin
                        // drop the rest of the reference, restart the stream
                        cut = 1'b1;
                     end else begin
                        push_stim(back_dist[7:0], 1'b0);
                        added++;
                        if (nib == 0) begin
                           third = ($urandom_range(99) < big_pct) ?
                                   BYTE_W'($urandom_range(128, 255)) :
                                   BYTE_W'($urandom_range(0, 31));
                           push_stim(third, 1'b0);
                           added++;
                           run_len = longint'(third) + longint'(LONG_BIAS);
                        end else begin
                           run_len = longint'(nib) + longint'(SHORT_BIAS);
                        end
                        if (longint'(back_dist) + 1 <= made)
                           made += (run_len < out_len - made) ? run_len : out_len - made;
                     end
                  end
               end
            end
            if (!cut && made >= out_len && $urandom_range(1) == 1) begin
               push_stim(BYTE_W'($urandom), 1'b0);
               added++;
            end
         end
      end
   endfunction

   // Offer one byte, with a random idle gap first; return at the edge that took it
   task automatic drive_item(logic [BYTE_W-1:0] d, logic s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_compressed_byte <= d;
      req_stream_start    <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_byte(d, s);
   endtask

   task automatic run_stim();
      comp_byte_type item;
      while (stim_q.size() != 0) begin
         item = stim_q.pop_front();
         drive_item(item.data, item.start);
      end
   endtask

   // Drop valid, wait for every expected item, then let a parse-only byte finish
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(logic [LEN_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_length(v);
   endtask

   task automatic run_phase(int idle, int stall, bit hold, int n_items, logic [LEN_W-1:0] len,
                            int lit_pct, int long_pct, int big_pct);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      write_length(len);
      build_streams(n_items, longint'(len), lit_pct, long_pct, big_pct);
      if (hold) hold_left = HOLD_CYCLES;
      run_stim();
      settle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Zero length: every byte lands past the end, with or without a new stream
      write_length('0);
      push_stim(8'hA5, 1'b1);
      push_stim(8'h5A, 1'b0);
      run_stim();
      settle();

      // Directed stream, length 100: three literals, two at the byte extremes,
      // a reference to before the stream start, an overlapping short copy,
      // the longest short copy, the shortest long copy, and the longest long
      // copy clamped at the end of output, then one byte past the end.
      write_length(LEN_W'(100));
      push_stim(8'hE0, 1'b1);
      push_stim(8'h00, 1'b0);
      push_stim(8'hFF, 1'b0);
      push_stim(8'h5A, 1'b0);
      push_stim(8'h1F, 1'b0);
      push_stim(8'hFF, 1'b0);
      push_stim(8'h10, 1'b0);
      push_stim(8'h00, 1'b0);
      push_stim(8'hF0, 1'b0);
      push_stim(8'h01, 1'b0);
      push_stim(8'h00, 1'b0);
      push_stim(8'h03, 1'b0);
      push_stim(8'h00, 1'b0);
      push_stim(8'h00, 1'b0);
      push_stim(8'h00, 1'b0);
      push_stim(8'hFF, 1'b0);
      push_stim(8'h55, 1'b0);
      run_stim();
      settle();

      // Unbounded length, no idling: long streams that wrap the history
      run_phase(0, 0, 1'b0, 80, LEN_MAX, 30, 60, 70);
      // Sender idles often, medium lengths
      run_phase(59, 0, 1'b0, 60, LEN_W'($urandom_range(64, 600)), 50, 20, 15);
      // Receiver stalls often, short lengths: many clamps and past-the-end bytes
      run_phase(0, 59, 1'b0, 60, LEN_W'($urandom_range(1, 40)), 50, 30, 15);
      // Both sides idle
      run_phase(32, 32, 1'b0, 60, LEN_W'($urandom_range(100, 2000)), 45, 25, 15);
      // Receiver holds off for a long stretch while the sender keeps offering
      run_phase(0, 20, 1'b1, 50, LEN_W'($urandom_range(300, 3000)), 40, 20, 15);

      if (tracker.mismatches == 0 && tracker.expected_beats.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- lz77_flag_byte_decoder.f -----
rtl/core/lz77fb_pkg.sv
rtl/core/lz77fb_ctrl.sv
rtl/core/lz77fb_dpath.sv
rtl/core/lz77_flag_byte_decoder.sv
test/tb_top.sv
